>>> rtl/uss_pkg.sv
package uss_pkg;

    // Default number of slots in the store
    localparam int CAPACITY_DEF = 64;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;
    localparam int OUT_W   = 7;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

>>> rtl/uss_cell.sv
module uss_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CNT_W-1:0]            count,
    input  logic [uss_pkg::VALUE_W-1:0] query,
    input  logic                        wr_en,
    input  logic [CNT_W-1:0]            wr_idx,
    input  logic [uss_pkg::VALUE_W-1:0] wr_data,
    input  logic                        in_vld,
    input  logic                        in_hit,
    input  logic [CNT_W-1:0]            in_pos,
    input  logic [uss_pkg::VALUE_W-1:0] in_last,
    output logic                        out_vld,
    output logic                        out_hit,
    output logic [CNT_W-1:0]            out_pos,
    output logic [uss_pkg::VALUE_W-1:0] out_last
);

    import uss_pkg::*;

    localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

    logic [VALUE_W-1:0] entry_reg;
    logic               vld_reg;
    logic               hit_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [VALUE_W-1:0] last_reg;

    logic               match;
    logic               hit_next;
    logic [CNT_W-1:0]   pos_next;
    logic [VALUE_W-1:0] last_next;

    // Compare the held entry against the query while the token passes
    always_comb
    begin
        match     = (IDX < count) && (entry_reg == query);
        hit_next  = in_hit | match;
        pos_next  = match ? IDX : in_pos;
        last_next = (IDX_P1 == count) ? entry_reg : in_last;
    end

    // Load the entry on a write addressed to this slot
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == IDX))
        begin
            entry_reg <= wr_data;
        end
    end

    // Advance the token valid flag one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    // Advance the token payload
    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            hit_reg  <= hit_next;
            pos_reg  <= pos_next;
            last_reg <= last_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_hit  = hit_reg;
    assign out_pos  = pos_reg;
    assign out_last = last_reg;

endmodule

>>> rtl/unordered_set_store.sv
// Each item: a registered start launches the search token, which walks the cell chain
// one slot per cycle; the store is updated as the token leaves the last cell, the
// output register is loaded and the controller returns to idle, where the next item
// is accepted. A stalled result holds the next output load.
// Reset clears the element count and all control state; slot contents are not
// cleared and no clearing pass runs, since only slots below the count are read.
module unordered_set_store #(
    parameter int CAPACITY = uss_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [uss_pkg::MODE_W-1:0]         mode,
    input  logic signed [uss_pkg::VALUE_W-1:0] value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               found,
    output logic [uss_pkg::OUT_W-1:0]          position,
    output logic [uss_pkg::OUT_W-1:0]          count_after,
    output logic                               full_error
);

    import uss_pkg::*;

    localparam int               CNT_W   = $clog2(CAPACITY + 1);
    localparam int               EXT_W   = CNT_W + OUT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t             state_reg;
    state_t             state_next;
    logic               start_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               res_found_reg;
    logic [CNT_W-1:0]   res_pos_reg;
    logic               res_err_reg;
    logic               res_err_next;

    logic               rsp_valid_reg;
    logic               found_reg;
    logic [OUT_W-1:0]   position_reg;
    logic [OUT_W-1:0]   count_after_reg;
    logic               full_error_reg;

    logic               accept;
    logic               load_out;
    logic               wr_en;
    logic [CNT_W-1:0]   wr_idx;
    logic [VALUE_W-1:0] wr_data;
    logic [EXT_W-1:0]   pos_ext;
    logic [EXT_W-1:0]   cnt_ext;

    // Token links between cells
    logic               tok_vld  [0:CAPACITY];
    logic               tok_hit  [0:CAPACITY];
    logic [CNT_W-1:0]   tok_pos  [0:CAPACITY];
    logic [VALUE_W-1:0] tok_last [0:CAPACITY];

    logic               tail_vld;
    logic               tail_hit;
    logic [CNT_W-1:0]   tail_pos;
    logic [VALUE_W-1:0] tail_last;

    assign accept = req_valid && !req_stall;

    // Seed the token: absent value reports the current count
    assign tok_vld[0]  = start_reg;
    assign tok_hit[0]  = 1'b0;
    assign tok_pos[0]  = count_reg;
    assign tok_last[0] = '0;

    // Row of slot cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        uss_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (count_reg),
            .query    (value_reg),
            .wr_en    (wr_en),
            .wr_idx   (wr_idx),
            .wr_data  (wr_data),
            .in_vld   (tok_vld[i]),
            .in_hit   (tok_hit[i]),
            .in_pos   (tok_pos[i]),
            .in_last  (tok_last[i]),
            .out_vld  (tok_vld[i+1]),
            .out_hit  (tok_hit[i+1]),
            .out_pos  (tok_pos[i+1]),
            .out_last (tok_last[i+1])
        );
    end

    assign tail_vld  = tok_vld[CAPACITY];
    assign tail_hit  = tok_hit[CAPACITY];
    assign tail_pos  = tok_pos[CAPACITY];
    assign tail_last = tok_last[CAPACITY];

    // Next state, store update and output load
    always_comb
    begin
        state_next   = state_reg;
        req_stall    = 1'b1;
        count_next   = count_reg;
        wr_en        = 1'b0;
        wr_idx       = count_reg;
        wr_data      = value_reg;
        res_err_next = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail_vld)
                begin
                    state_next = ST_OUT;
                    if ((mode_reg == MODE_INSERT) && !tail_hit)
                    begin
                        if (count_reg != CAP_CNT)
                        begin
                            wr_en      = 1'b1;
                            wr_idx     = count_reg;
                            wr_data    = value_reg;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_err_next = 1'b1;
                        end
                    end
                    else if ((mode_reg == MODE_DELETE) && tail_hit)
                    begin
                        // move the last entry into the freed slot
                        wr_en      = 1'b1;
                        wr_idx     = tail_pos;
                        wr_data    = tail_last;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            count_reg <= count_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
    end

    // Capture the search result at the chain tail
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SCAN) && tail_vld)
        begin
            res_found_reg <= tail_hit;
            res_pos_reg   <= tail_pos;
            res_err_reg   <= res_err_next;
        end
    end

    // Zero-extend or truncate position and count to the output width
    assign pos_ext = EXT_W'(res_pos_reg);
    assign cnt_ext = EXT_W'(count_reg);

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_reg       <= res_found_reg;
            position_reg    <= pos_ext[OUT_W-1:0];
            count_after_reg <= cnt_ext[OUT_W-1:0];
            full_error_reg  <= res_err_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign count_after = count_after_reg;
    assign full_error  = full_error_reg;

endmodule
